[hdl/rbmf_pkg.sv]
// ----------------------------------------------------------------------------
// rbmf_pkg
// Shared constants and types of the RGB box mean filter.
// ----------------------------------------------------------------------------
package rbmf_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_WINDOW = 7;
  localparam int LS_DEPTH   = MAX_WIDTH * MAX_WINDOW;
  localparam int LS_AW      = $clog2(LS_DEPTH);
  localparam logic [LS_AW-1:0] LS_LAST = LS_AW'(LS_DEPTH - 1);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_t;
endpackage

[hdl/rbmf_if.sv]
// ----------------------------------------------------------------------------
// rbmf_in_if / rbmf_out_if
// Valid/ready channels carrying input pixels and output results.
// ----------------------------------------------------------------------------
interface rbmf_in_if;
  logic             valid;
  logic             ready;
  rbmf_pkg::pixel_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rbmf_out_if;
  logic              valid;
  logic              ready;
  rbmf_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/rgb_box_mean_filter_core.sv]
// ----------------------------------------------------------------------------
// rgb_box_mean_filter_core
// Streaming n-by-n box mean over RGB pixels with a circular line store.
// ----------------------------------------------------------------------------
// Each beat is handled on its own: the pixel is written to the line store,
// then the window is read back one pixel per cycle through the single RAM
// read port (n*n reads, up to 49), and the three sums go through a shared
// serial divider. A beat that yields a result holds the input from its
// acceptance until the result register is loaded; other beats do not hold
// it. A new beat is taken only when the output register is empty or
// drains in that cycle. Store addresses are wrapping counters. No clearing
// pass after reset.
module rgb_box_mean_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  rbmf_in_if.sink     in_ch,
  rbmf_out_if.source  out_ch
);
  import rbmf_pkg::*;

  logic [23:0] mem [LS_DEPTH];
  logic [23:0] rd_q;
  logic        we;

  logic [10:0] fw_r;
  logic [12:0] fh_r;
  logic [2:0]  wn_r;
  logic [10:0] w;
  logic [12:0] h;
  logic [2:0]  n, lo, a;
  logic [14:0] lag;
  logic [11:0] back_off;

  logic [10:0] in_col_r, out_col_r;
  logic [12:0] in_row_r, out_row_r;
  logic [14:0] lag_r;

  logic [LS_AW-1:0] wa_r, ob_r, rowa_r, raddr_r;
  logic [LS_AW-1:0] wa_inc, ob_inc, ra_inc, row_next, start_addr;
  logic [LS_AW:0]   ob_ext, boff_ext, row_sum;

  state_t st_r, st_nxt;
  logic [2:0]  dr_r, dc_r;
  logic        rvalid_r, rin_r, dbusy_r;
  logic [13:0] sr_r, sg_r, sb_r;
  logic [5:0]  cnt_r;
  logic        div_start, div_done, div_done_r;
  logic [7:0]  qr, qg, qb;
  result_t     res_r;
  logic        ovalid_r;
  logic        accept;
  logic        pix_in;
  logic        cfg_hit;
  logic        last_out;
  logic signed [14:0] rr, cc;
  logic        in_win;
  logic        last_dc, last_dr;

  always_comb begin
    w = (fw_r == 11'd0) ? 11'd1 : ((fw_r > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : fw_r);
    h = (fh_r == 13'd0) ? 13'd1 : fh_r;
    n = (wn_r == 3'd0) ? 3'd1 : wn_r;
    lo = n >> 1;
    a = 3'(n - 3'd1 - lo);
  end
  // a <= 3, w <= 1024
  assign lag = 15'(a) * 15'(w) + 15'(a);

  assign in_ch.ready = (st_r == ST_IDLE) && !cfg_we && (!ovalid_r || out_ch.ready);
  assign accept  = in_ch.valid && in_ch.ready;
  assign pix_in  = (in_row_r < h);
  assign we      = accept && pix_in && !in_ch.data.kind;
  assign cfg_hit = cfg_we && (cfg_index <= REG_WINDOW);
  assign last_out = (out_row_r == 13'(h - 13'd1)) && (out_col_r == 11'(w - 11'd1));

  // window position of the current read
  always_comb begin
    rr = $signed({2'b0, out_row_r}) + $signed({12'd0, dr_r}) - $signed({12'd0, lo});
    cc = $signed({4'b0, out_col_r}) + $signed({12'd0, dc_r}) - $signed({12'd0, lo});
    in_win = (rr >= 0) && (rr < $signed({2'b0, h})) && (cc >= 0)
             && (cc < $signed({4'b0, w}));
  end

  // linear store addresses, all modulo the store depth
  assign wa_inc = (wa_r == LS_LAST) ? '0 : LS_AW'(wa_r + 1'b1);
  assign ob_inc = (ob_r == LS_LAST) ? '0 : LS_AW'(ob_r + 1'b1);
  assign ra_inc = (raddr_r == LS_LAST) ? '0 : LS_AW'(raddr_r + 1'b1);

  assign back_off = 12'(lo) * 12'(w) + 12'(lo);
  assign ob_ext   = {1'b0, ob_r};
  assign boff_ext = (LS_AW+1)'(back_off);
  always_comb begin
    if (ob_ext >= boff_ext) start_addr = LS_AW'(ob_ext - boff_ext);
    else start_addr = LS_AW'(ob_ext + (LS_AW+1)'(LS_DEPTH) - boff_ext);
  end

  assign row_sum  = {1'b0, rowa_r} + (LS_AW+1)'(w);
  assign row_next = (row_sum >= (LS_AW+1)'(LS_DEPTH)) ?
                    LS_AW'(row_sum - (LS_AW+1)'(LS_DEPTH)) : row_sum[LS_AW-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[wa_r] <= {in_ch.data.red, in_ch.data.green, in_ch.data.blue};
    rd_q <= mem[raddr_r];
  end

  assign last_dc = (dc_r == 3'(n - 3'd1));
  assign last_dr = (dr_r == 3'(n - 3'd1));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (accept && !(pix_in && in_ch.data.kind) && lag_r >= lag) st_nxt = ST_READ;
      ST_READ: if (last_dc && last_dr) st_nxt = ST_DIV;
      ST_DIV:  if (div_done_r) st_nxt = ST_OUT;
      ST_OUT:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign div_start = (st_r == ST_DIV) && !rvalid_r && !dbusy_r;

  rbmf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num_r(14'(sr_r + 14'(cnt_r >> 1))), .num_g(14'(sg_r + 14'(cnt_r >> 1))),
    .num_b(14'(sb_r + 14'(cnt_r >> 1))),
    .den((cnt_r == 6'd0) ? 6'd1 : cnt_r),
    .done(div_done), .q_r(qr), .q_g(qg), .q_b(qb)
  );

  // registers and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 11'd640; fh_r <= 13'd480; wn_r <= 3'd3;
      in_col_r <= '0; in_row_r <= '0; out_col_r <= '0; out_row_r <= '0; lag_r <= '0;
      wa_r <= '0; ob_r <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        REG_WIDTH:  fw_r <= cfg_data[10:0];
        REG_HEIGHT: fh_r <= cfg_data;
        default:    wn_r <= cfg_data[2:0];
      endcase
      in_col_r <= '0; in_row_r <= '0; out_col_r <= '0; out_row_r <= '0; lag_r <= '0;
      wa_r <= '0; ob_r <= '0;
    end else if ((st_r == ST_OUT) && last_out) begin
      in_col_r <= '0; in_row_r <= '0; out_col_r <= '0; out_row_r <= '0; lag_r <= '0;
      wa_r <= '0; ob_r <= '0;
    end else begin
      if (we) begin
        wa_r <= wa_inc;
        if (in_col_r + 11'd1 >= w) begin
          in_col_r <= '0; in_row_r <= in_row_r + 13'd1;
        end else in_col_r <= in_col_r + 11'd1;
      end
      if (accept && !(pix_in && in_ch.data.kind) && lag_r < lag) lag_r <= lag_r + 15'd1;
      if (st_r == ST_OUT) begin
        ob_r <= ob_inc;
        if (out_col_r + 11'd1 >= w) begin
          out_col_r <= '0; out_row_r <= out_row_r + 13'd1;
        end else out_col_r <= out_col_r + 11'd1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; rvalid_r <= 1'b0; div_done_r <= 1'b0; dbusy_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rvalid_r <= (st_r == ST_READ);
      div_done_r <= div_done;
      if (div_start) dbusy_r <= 1'b1;
      else if (st_r == ST_OUT) dbusy_r <= 1'b0;
    end
  end

  // window scan and sums
  always_ff @(posedge clk) begin
    rin_r <= in_win;
    if (accept) begin
      dr_r <= '0; dc_r <= '0;
      rowa_r <= start_addr; raddr_r <= start_addr;
    end else if (st_r == ST_READ) begin
      if (last_dc) begin
        dc_r <= '0; dr_r <= dr_r + 3'd1;
        rowa_r <= row_next; raddr_r <= row_next;
      end else begin
        dc_r <= dc_r + 3'd1; raddr_r <= ra_inc;
      end
    end
    if (accept) begin
      sr_r <= '0; sg_r <= '0; sb_r <= '0; cnt_r <= '0;
    end else if (rvalid_r && rin_r) begin
      sr_r <= sr_r + 14'(rd_q[23:16]);
      sg_r <= sg_r + 14'(rd_q[15:8]);
      sb_r <= sb_r + 14'(rd_q[7:0]);
      cnt_r <= cnt_r + 6'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (st_r == ST_OUT) ovalid_r <= 1'b1;
    else if (out_ch.ready) ovalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_OUT) res_r <= '{red: qr, green: qg, blue: qb, frame_end: last_out};
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = res_r;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_ch.ready) else $error("beat taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT) |-> (!ovalid_r || out_ch.ready)) else $error("result overwritten");
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_DIV)) else $error("divider out of step");
`endif
endmodule

[hdl/rbmf_div.sv]
// ----------------------------------------------------------------------------
// rbmf_div
// Restoring divider for three channel sums by one shared count, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module rbmf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [13:0] num_r,
  input  logic [13:0] num_g,
  input  logic [13:0] num_b,
  input  logic [5:0]  den,
  output logic        done,
  output logic [7:0]  q_r,
  output logic [7:0]  q_g,
  output logic [7:0]  q_b
);
  logic [13:0] nr_r, ng_r, nb_r;
  logic [13:0] qr_r, qg_r, qb_r;
  logic [13:0] rr_r, rg_r, rb_r;
  logic [5:0]  den_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic [14:0] tr, tg, tb;

  assign tr = {rr_r, nr_r[13]};
  assign tg = {rg_r, ng_r[13]};
  assign tb = {rb_r, nb_r[13]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd13;
      nr_r <= num_r; ng_r <= num_g; nb_r <= num_b;
      rr_r <= '0; rg_r <= '0; rb_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      nr_r <= nr_r << 1; ng_r <= ng_r << 1; nb_r <= nb_r << 1;
      if (tr >= {9'd0, den_r}) begin
        rr_r <= 14'(tr - {9'd0, den_r}); qr_r <= {qr_r[12:0], 1'b1};
      end else begin
        rr_r <= tr[13:0]; qr_r <= {qr_r[12:0], 1'b0};
      end
      if (tg >= {9'd0, den_r}) begin
        rg_r <= 14'(tg - {9'd0, den_r}); qg_r <= {qg_r[12:0], 1'b1};
      end else begin
        rg_r <= tg[13:0]; qg_r <= {qg_r[12:0], 1'b0};
      end
      if (tb >= {9'd0, den_r}) begin
        rb_r <= 14'(tb - {9'd0, den_r}); qb_r <= {qb_r[12:0], 1'b1};
      end else begin
        rb_r <= tb[13:0]; qb_r <= {qb_r[12:0], 1'b0};
      end
      if (cnt_r == 4'd0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 4'd1;
    end
  end

  assign done = busy_r && (cnt_r == 4'd0);
  // quotient bits valid from the cycle after done and held while idle; top level samples them in ST_OUT
  assign q_r = qr_r[7:0];
  assign q_g = qg_r[7:0];
  assign q_b = qb_r[7:0];
endmodule
